### hdl/fir_pkg.sv
// fir_pkg: shared constants, types and control struct of the FIR filter.
// No dependencies; imported by every fir_* module.
package fir_pkg;

    localparam int TAPS       = 8;
    localparam int NREG       = 8;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int NPAIR      = (TAPS + 1) / 2;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_SHIFT = 14;
    localparam int Q_W        = ACC_W - FRAC_SHIFT;
    localparam int REG_IDX_W  = $clog2(NREG);
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int DATA_W     = 32;

    localparam logic signed [COEF_W-1:0]   COEF0_RESET = COEF_W'(16384);
    localparam logic signed [COEF_W-1:0]   COEF_RESET  = '0;
    localparam logic signed [ACC_W-1:0]    ROUND_HALF  = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX     = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN     = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    // pipeline control handed to the cells and the adder tree
    typedef struct packed {
        logic adv;    // all stages move one step
        logic take;   // a new word enters the delay line
    } pipe_ctl_t;

endpackage

### hdl/fir_filter.sv
// fir_filter: top level of the 8-tap direct-form FIR filter.
// Depends on fir_pkg, fir_regs, fir_cell, fir_sum.
//
//  port group   direction  handshake                       payload
//  sample       in         sample_valid / sample_ready     sample
//  result       out        result_valid / result_ready     filtered, clipped
//  apb          in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// One word per clock while the result is not stalled. The product is registered at the
// accepting edge, then pair sum, total and round/saturate; result_valid rises with that last stage.
// The row of tap cells shifts the delay line on each accepted word; all cells
// multiply in parallel, then a registered adder tree finishes the sum.
// A stalled result freezes the whole pipeline; sample_ready drops with it.
// Reset clears the delay line and the valid bits and loads coef_0 = 1.0.
module fir_filter
    import fir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  sample_t           sample,
    output logic              result_valid,
    input  logic              result_ready,
    output sample_t           filtered,
    output logic              clipped,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    coef_t     coef  [NREG];
    sample_t   chain [TAPS];
    prod_t     prod  [TAPS];
    pipe_ctl_t ctl;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    // whole pipe moves unless the output word is held
    assign ctl.adv      = !out_valid_reg || result_ready;
    assign ctl.take     = sample_valid && ctl.adv;
    assign sample_ready = ctl.adv;
    assign result_valid = out_valid_reg;

    fir_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // cell k sees the word k steps back; its tap holds it for cell k+1
    assign chain[0] = sample;

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        if (k < TAPS - 1)
        begin : g_mid
            fir_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .shift_in  (chain[k]),
                .coef      (coef[k]),
                .shift_out (chain[k+1]),
                .prod      (prod[k])
            );
        end
        else
        begin : g_last
            fir_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .shift_in  (chain[k]),
                .coef      (coef[k]),
                .shift_out (),
                .prod      (prod[k])
            );
        end
    end

    fir_sum u_sum (
        .clk      (clk),
        .ctl      (ctl),
        .prod     (prod),
        .filtered (filtered),
        .clipped  (clipped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            s1_valid_reg  <= sample_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

`ifndef SYNTHESIS
    // a saturated word is one of the two rails
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && clipped |-> filtered == SAT_MAX || filtered == SAT_MIN)
        else $error("clipped word not at a rail");

    // delay line moves only on an accepted word
    a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(sample_valid && sample_ready) |=> $stable(chain[1]))
        else $error("delay line shifted without a word");

    // a bubble at the input stays a bubble in the product stage
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready && !sample_valid |=> !s1_valid_reg)
        else $error("product stage valid without a word");

    // a word parked at the output blocks the input
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(s3_valid_reg))
        else $error("pipeline moved under a stall");
`endif

endmodule

### hdl/fir_regs.sv
// fir_regs: APB coefficient register file of the FIR filter.
// Depends on fir_pkg.
module fir_regs
    import fir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output coef_t             coef [NREG]
);

    coef_t                coef_reg [NREG];
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
            begin
                coef_reg[i] <= (i == 0) ? COEF0_RESET : COEF_RESET;
            end
        end
        else if (wr_en)
        begin
            coef_reg[idx] <= pwdata[COEF_W-1:0];
        end
    end

    // reads sign-extend the 16-bit coefficient
    assign prdata = DATA_W'(coef_reg[idx]);

    always_comb
    begin
        for (int i = 0; i < NREG; i++)
        begin
            coef[i] = coef_reg[i];
        end
    end

endmodule

### hdl/fir_cell.sv
// fir_cell: one tap of the delay line with its registered product.
// Depends on fir_pkg.
module fir_cell
    import fir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  sample_t   shift_in,
    input  coef_t     coef,
    output sample_t   shift_out,
    output prod_t     prod
);

    sample_t tap_reg;
    prod_t   prod_reg;

    // history word, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (ctl.take)
        begin
            tap_reg <= shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            prod_reg <= shift_in * coef;
        end
    end

    assign shift_out = tap_reg;
    assign prod      = prod_reg;

endmodule

### hdl/fir_sum.sv
// fir_sum: registered adder tree, rounding and saturation of the FIR filter.
// Depends on fir_pkg.
module fir_sum
    import fir_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  prod_t     prod [TAPS],
    output sample_t   filtered,
    output logic      clipped
);

    logic signed [PAIR_W-1:0] pair_reg  [NPAIR];
    logic signed [PAIR_W-1:0] pair_next [NPAIR];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [Q_W-1:0]    q;
    sample_t                  filtered_reg;
    sample_t                  filtered_next;
    logic                     clipped_reg;
    logic                     clipped_next;

    always_comb
    begin
        for (int j = 0; j < NPAIR; j++)
        begin
            pair_next[j] = PAIR_W'(prod[2*j]);
            if (2*j + 1 < TAPS)
            begin
                pair_next[j] = pair_next[j] + PAIR_W'(prod[2*j+1]);
            end
        end
    end

    // total plus half an LSB, so the shift below rounds to nearest
    always_comb
    begin
        acc_next = ROUND_HALF;
        for (int j = 0; j < NPAIR; j++)
        begin
            acc_next = acc_next + ACC_W'(pair_reg[j]);
        end
    end

    assign q = acc_reg[ACC_W-1:FRAC_SHIFT];

    always_comb
    begin
        filtered_next = q[SAMPLE_W-1:0];
        clipped_next  = 1'b0;
        if (q[Q_W-1:SAMPLE_W-1] != {(Q_W-SAMPLE_W+1){q[SAMPLE_W-1]}})
        begin
            clipped_next  = 1'b1;
            filtered_next = q[Q_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            pair_reg     <= pair_next;
            acc_reg      <= acc_next;
            filtered_reg <= filtered_next;
            clipped_reg  <= clipped_next;
        end
    end

    assign filtered = filtered_reg;
    assign clipped  = clipped_reg;

endmodule
